FILE: src/tram_pkg.sv
package tram_pkg;

  localparam int unsigned DivW          = 64;
  localparam int unsigned DvsW          = 48;
  localparam int unsigned SpeedWindowMs = 1000;
  localparam int unsigned ScaleMs       = 1000;
  localparam int unsigned ScalePct      = 10000;

  localparam logic [47:0] Max48  = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] MaxPct = 16'hFFFF;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_END    = 3'd1,
    OP_BYTES  = 3'd2,
    OP_UPDATE = 3'd3,
    OP_QUERY  = 3'd4
  } tram_op_e;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic cur_clr;
    logic cur_inc;
    logic cur_slot;
    logic walk_clr;
    logic mem_rd;
    logic walk_acc;
    logic walk_end;
    logic upd;
    logic div_avg;
    logic div_pct;
    logic div_eta;
    logic avg_wr;
    logic pct_wr;
    logic pct_zero;
    logic eta_wr;
    logic eta_zero;
    logic g_clr;
    logic g_acc;
  } tram_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       found;
    logic       cur_active;
    logic       cur_end;
    logic       cur_last;
    logic       k_end;
    logic       avg_ok;
    logic       pct_ok;
    logic       eta_ok;
    logic       div_done;
  } tram_status_t;

  typedef struct packed {
    logic [47:0] global_speed;
    logic [47:0] global_bytes;
    logic [39:0] last_update_ms;
    logic [39:0] start_time_ms;
    logic [47:0] eta_ms;
    logic [47:0] average_speed;
    logic [47:0] current_speed;
    logic [15:0] percent_x100;
    logic [47:0] moved_bytes;
    logic [39:0] byte_total;
  } tram_result_t;

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? Max48 : s[47:0];
  endfunction

endpackage

FILE: src/tram_div.sv
module tram_div import tram_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DvsW-1:0] rem_q;
  logic [DvsW-1:0] dvs_q;
  logic [DivW-1:0] quo_q;
  logic [DvsW:0]   trial;
  logic [DvsW:0]   diff;
  logic            ge;

  assign trial = {rem_q, quo_q[DivW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DvsW-1:0] : trial[DvsW-1:0];
      quo_q <= {quo_q[DivW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without run");
`endif

endmodule

FILE: src/tram_dp.sv
module tram_dp import tram_pkg::*; #(
  parameter int unsigned SESSIONS          = 4,
  parameter int unsigned HISTORY_DEPTH     = 16,
  parameter int unsigned HISTORY_WINDOW_MS = 5000
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [2:0]   op_i,
  input  logic [1:0]   slot_i,
  input  logic [39:0]  amount_i,
  input  logic [39:0]  now_i,
  input  tram_cmd_t    cmd_i,
  output tram_status_t st_o,
  output logic         found_o,
  output tram_result_t res_o
);

  localparam int unsigned SIW  = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int unsigned CURW = $clog2(SESSIONS + 1);
  localparam int unsigned HW   = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW   = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned PW   = CW + 1;

  localparam logic [PW-1:0]   DepthP   = PW'(HISTORY_DEPTH);
  localparam logic [CW-1:0]   DepthC   = CW'(HISTORY_DEPTH);
  localparam logic [40:0]     WinHist  = 41'(HISTORY_WINDOW_MS);
  localparam logic [40:0]     WinSpeed = 41'(SpeedWindowMs);
  localparam logic [CURW-1:0] SessEnd  = CURW'(SESSIONS);
  localparam logic [CURW-1:0] SessLast = CURW'(SESSIONS - 1);

  function automatic logic [HW-1:0] wrap(input logic [PW-1:0] s);
    return (s >= DepthP) ? HW'(s - DepthP) : HW'(s);
  endfunction

  logic [2:0]      op_q;
  logic [1:0]      slot_q;
  logic [39:0]     amount_q;
  logic [39:0]     now_q;
  logic [CURW-1:0] cur_q;

  logic            active_q [SESSIONS];
  logic [39:0]     total_q  [SESSIONS];
  logic [47:0]     moved_q  [SESSIONS];
  logic [47:0]     cs_q     [SESSIONS];
  logic [47:0]     avg_q    [SESSIONS];
  logic [39:0]     start_q  [SESSIONS];
  logic [39:0]     last_q   [SESSIONS];
  logic [HW-1:0]   head_q   [SESSIONS];
  logic [CW-1:0]   count_q  [SESSIONS];

  logic [79:0]     hist_mem [SESSIONS][HISTORY_DEPTH];
  logic [79:0]     rd_q;

  logic [CW-1:0]   k_q;
  logic [CW-1:0]   dropn_q;
  logic            dropping_q;
  logic [47:0]     recent_q;
  logic [47:0]     gb_q;
  logic [47:0]     gs_q;
  logic [15:0]     pct_q;
  logic [47:0]     eta_q;

  logic [SIW-1:0]  ci;
  logic            slot_valid;
  logic            found;
  logic            bytes_go;
  logic [39:0]     total_c;
  logic [47:0]     moved_c;
  logic [47:0]     cs_c;
  logic [47:0]     avg_c;
  logic [39:0]     start_c;
  logic [HW-1:0]   head_c;
  logic [CW-1:0]   cnt_c;
  logic [47:0]     speed_c;
  logic [HW-1:0]   rpos;
  logic            full;
  logic [HW-1:0]   head_a;
  logic [CW-1:0]   cnt_a;
  logic [HW-1:0]   wpos;
  logic [HW-1:0]   head_e;
  logic [CW-1:0]   cnt_e;
  logic            is_recent;
  logic            is_old;
  logic [DivW-1:0] dvd;
  logic [DvsW-1:0] dvs;
  logic            div_start;
  logic            div_done;
  logic [DivW-1:0] quo;

  assign ci         = cur_q[SIW-1:0];
  assign slot_valid = 32'(slot_q) < SESSIONS;
  assign total_c    = total_q[ci];
  assign moved_c    = moved_q[ci];
  assign cs_c       = cs_q[ci];
  assign avg_c      = avg_q[ci];
  assign start_c    = start_q[ci];
  assign head_c     = head_q[ci];
  assign cnt_c      = count_q[ci];
  assign found      = slot_valid && active_q[ci];
  assign bytes_go   = cmd_i.exec && found && (op_q == OP_BYTES);
  assign speed_c    = (cs_c != '0) ? cs_c : avg_c;

  assign rpos   = wrap(PW'(head_c) + PW'(k_q));
  assign full   = cnt_c == DepthC;
  assign head_a = full ? wrap(PW'(head_c) + PW'(1)) : head_c;
  assign cnt_a  = full ? cnt_c - CW'(1) : cnt_c;
  assign wpos   = wrap(PW'(head_a) + PW'(cnt_a));
  assign head_e = wrap(PW'(head_c) + PW'(dropn_q));
  assign cnt_e  = cnt_c - dropn_q;

  assign is_recent = (41'(rd_q[79:40]) + WinSpeed) >= 41'(now_q);
  assign is_old    = (41'(rd_q[79:40]) + WinHist) < 41'(now_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q     <= op_i;
      slot_q   <= slot_i;
      amount_q <= amount_i;
      now_q    <= now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else begin
      priority if (cmd_i.load_in) begin
        cur_q <= CURW'(slot_i);
      end else if (cmd_i.cur_slot) begin
        cur_q <= CURW'(slot_q);
      end else if (cmd_i.cur_clr) begin
        cur_q <= '0;
      end else if (cmd_i.cur_inc) begin
        cur_q <= cur_q + CURW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SESSIONS; i++) begin
        active_q[i] <= 1'b0;
        total_q[i]  <= '0;
        moved_q[i]  <= '0;
        cs_q[i]     <= '0;
        avg_q[i]    <= '0;
        start_q[i]  <= '0;
        last_q[i]   <= '0;
        head_q[i]   <= '0;
        count_q[i]  <= '0;
      end
    end else begin
      if (cmd_i.exec && slot_valid) begin
        unique case (op_q)
          OP_START: begin
            active_q[ci] <= 1'b1;
            total_q[ci]  <= amount_q;
            moved_q[ci]  <= '0;
            cs_q[ci]     <= '0;
            avg_q[ci]    <= '0;
            start_q[ci]  <= now_q;
            last_q[ci]   <= now_q;
            head_q[ci]   <= '0;
            count_q[ci]  <= '0;
          end
          OP_END: begin
            active_q[ci] <= 1'b0;
            head_q[ci]   <= '0;
            count_q[ci]  <= '0;
          end
          OP_BYTES: begin
            if (active_q[ci]) begin
              moved_q[ci] <= sat_add48(moved_c, 48'(amount_q));
              last_q[ci]  <= now_q;
              head_q[ci]  <= head_a;
              count_q[ci] <= cnt_a + CW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.walk_end) begin
        head_q[ci]  <= head_e;
        count_q[ci] <= cnt_e;
        if (cmd_i.upd) begin
          cs_q[ci] <= recent_q;
        end
      end
      if (cmd_i.avg_wr) begin
        avg_q[ci] <= (quo > 64'(Max48)) ? Max48 : quo[47:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bytes_go) begin
      hist_mem[ci][wpos] <= {now_q, amount_q};
    end
    if (cmd_i.mem_rd) begin
      rd_q <= hist_mem[ci][rpos];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q        <= '0;
      dropn_q    <= '0;
      dropping_q <= 1'b0;
      recent_q   <= '0;
      gb_q       <= '0;
      gs_q       <= '0;
      pct_q      <= '0;
      eta_q      <= '0;
    end else begin
      if (cmd_i.walk_clr) begin
        k_q        <= '0;
        dropn_q    <= '0;
        dropping_q <= 1'b1;
        recent_q   <= '0;
      end
      if (cmd_i.mem_rd) begin
        k_q <= k_q + CW'(1);
      end
      if (cmd_i.walk_acc) begin
        if (is_recent) begin
          recent_q <= sat_add48(recent_q, 48'(rd_q[39:0]));
        end
        if (dropping_q && is_old) begin
          dropn_q <= dropn_q + CW'(1);
        end else begin
          dropping_q <= 1'b0;
        end
      end
      if (cmd_i.g_clr) begin
        gb_q <= '0;
        gs_q <= '0;
      end else if (cmd_i.g_acc && active_q[ci]) begin
        gb_q <= sat_add48(gb_q, moved_c);
        gs_q <= sat_add48(gs_q, cs_c);
      end
      if (cmd_i.pct_zero) begin
        pct_q <= '0;
      end else if (cmd_i.pct_wr) begin
        pct_q <= (quo > 64'(MaxPct)) ? MaxPct : quo[15:0];
      end
      if (cmd_i.eta_zero) begin
        eta_q <= '0;
      end else if (cmd_i.eta_wr) begin
        eta_q <= (quo > 64'(Max48)) ? Max48 : quo[47:0];
      end
    end
  end

  always_comb begin
    dvd = '0;
    dvs = '0;
    priority if (cmd_i.div_avg) begin
      dvd = 64'(moved_c) * 64'(ScaleMs);
      dvs = DvsW'(now_q - start_c);
    end else if (cmd_i.div_pct) begin
      dvd = 64'(moved_c) * 64'(ScalePct);
      dvs = DvsW'(total_c);
    end else if (cmd_i.div_eta) begin
      dvd = 64'(48'(total_c) - moved_c) * 64'(ScaleMs);
      dvs = speed_c;
    end
  end

  assign div_start = cmd_i.div_avg | cmd_i.div_pct | cmd_i.div_eta;

  tram_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign st_o.op         = op_q;
  assign st_o.found      = found;
  assign st_o.cur_active = active_q[ci];
  assign st_o.cur_end    = cur_q == SessEnd;
  assign st_o.cur_last   = cur_q == SessLast;
  assign st_o.k_end      = k_q == cnt_c;
  assign st_o.avg_ok     = now_q > start_c;
  assign st_o.pct_ok     = found && (total_c != '0);
  assign st_o.eta_ok     = found && (48'(total_c) > moved_c) && (speed_c != '0);
  assign st_o.div_done   = div_done;

  assign found_o              = found;
  assign res_o.byte_total     = found ? total_c : '0;
  assign res_o.moved_bytes    = found ? moved_c : '0;
  assign res_o.percent_x100   = found ? pct_q : '0;
  assign res_o.current_speed  = found ? cs_c : '0;
  assign res_o.average_speed  = found ? avg_c : '0;
  assign res_o.eta_ms         = found ? eta_q : '0;
  assign res_o.start_time_ms  = found ? start_c : now_q;
  assign res_o.last_update_ms = found ? last_q[ci] : now_q;
  assign res_o.global_bytes   = gb_q;
  assign res_o.global_speed   = gs_q;

endmodule

FILE: src/tram_ctrl.sv
module tram_ctrl import tram_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         out_free_i,
  output logic         out_load_o,
  input  tram_status_t st_i,
  output tram_cmd_t    cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE = 13'h0001,
    S_EXEC = 13'h0002,
    S_UCHK = 13'h0004,
    S_WREQ = 13'h0008,
    S_WDAT = 13'h0010,
    S_WEND = 13'h0020,
    S_AVGW = 13'h0040,
    S_GSUM = 13'h0080,
    S_PCT  = 13'h0100,
    S_PCTW = 13'h0200,
    S_ETA  = 13'h0400,
    S_ETAW = 13'h0800,
    S_OUT  = 13'h1000
  } state_e;

  state_e state_q, state_d;
  logic   upd_q, upd_d;

  always_comb begin
    state_d    = state_q;
    upd_d      = upd_q;
    cmd_o      = '0;
    cmd_o.upd  = upd_q;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        unique case (st_i.op)
          OP_BYTES: begin
            if (st_i.found) begin
              cmd_o.walk_clr = 1'b1;
              upd_d          = 1'b0;
              state_d        = S_WREQ;
            end else begin
              cmd_o.cur_clr = 1'b1;
              cmd_o.g_clr   = 1'b1;
              state_d       = S_GSUM;
            end
          end
          OP_UPDATE: begin
            cmd_o.cur_clr = 1'b1;
            upd_d         = 1'b1;
            state_d       = S_UCHK;
          end
          default: begin
            cmd_o.cur_clr = 1'b1;
            cmd_o.g_clr   = 1'b1;
            state_d       = S_GSUM;
          end
        endcase
      end
      S_UCHK: begin
        priority if (st_i.cur_end) begin
          cmd_o.cur_clr = 1'b1;
          cmd_o.g_clr   = 1'b1;
          state_d       = S_GSUM;
        end else if (st_i.cur_active) begin
          cmd_o.walk_clr = 1'b1;
          state_d        = S_WREQ;
        end else begin
          cmd_o.cur_inc = 1'b1;
        end
      end
      S_WREQ: begin
        if (st_i.k_end) begin
          state_d = S_WEND;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d      = S_WDAT;
        end
      end
      S_WDAT: begin
        cmd_o.walk_acc = 1'b1;
        state_d        = S_WREQ;
      end
      S_WEND: begin
        cmd_o.walk_end = 1'b1;
        priority if (upd_q && st_i.avg_ok) begin
          cmd_o.div_avg = 1'b1;
          state_d       = S_AVGW;
        end else if (upd_q) begin
          cmd_o.cur_inc = 1'b1;
          state_d       = S_UCHK;
        end else begin
          cmd_o.cur_clr = 1'b1;
          cmd_o.g_clr   = 1'b1;
          state_d       = S_GSUM;
        end
      end
      S_AVGW: begin
        if (st_i.div_done) begin
          cmd_o.avg_wr  = 1'b1;
          cmd_o.cur_inc = 1'b1;
          state_d       = S_UCHK;
        end
      end
      S_GSUM: begin
        cmd_o.g_acc = 1'b1;
        if (st_i.cur_last) begin
          cmd_o.cur_slot = 1'b1;
          state_d        = S_PCT;
        end else begin
          cmd_o.cur_inc = 1'b1;
        end
      end
      S_PCT: begin
        if (st_i.pct_ok) begin
          cmd_o.div_pct = 1'b1;
          state_d       = S_PCTW;
        end else begin
          cmd_o.pct_zero = 1'b1;
          state_d        = S_ETA;
        end
      end
      S_PCTW: begin
        if (st_i.div_done) begin
          cmd_o.pct_wr = 1'b1;
          state_d      = S_ETA;
        end
      end
      S_ETA: begin
        if (st_i.eta_ok) begin
          cmd_o.div_eta = 1'b1;
          state_d       = S_ETAW;
        end else begin
          cmd_o.eta_zero = 1'b1;
          state_d        = S_OUT;
        end
      end
      S_ETAW: begin
        if (st_i.div_done) begin
          cmd_o.eta_wr = 1'b1;
          state_d      = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      upd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      upd_q   <= upd_d;
    end
  end

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |-> out_free_i) else $error("result loaded over pending one");
  a_avg_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AVGW) |-> upd_q) else $error("average divide outside update");
  a_read_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mem_rd |-> !st_i.k_end) else $error("history read past fill");
`endif

endmodule

FILE: src/transfer_rate_and_eta_monitor_core.sv
// Transfer rate and ETA monitor.
// Input channel s_axis: one request per transfer event. tuser carries the
// operation (start, end, bytes, update, query), tdata the slot, amount and
// millisecond timestamp. Output channel m_axis: one result per request with
// the slot statistics in tdata and the found flag in tuser.
// Requests are handled one at a time. Every request sums the active slots
// into the global figures; bytes for an active slot first append to its
// history and walk it, and an update walks the history of every active slot
// and divides for its average. A percent or ETA figure uses the shared
// radix-2 divider, which with the history walks sets the time per request.
// The finished result sits in an output register, so a new request is taken
// while the receiver stalls; the block then waits only when a second result
// is ready before the first one left.
// Reset clears all sessions and global sums; no clearing pass is needed.
module transfer_rate_and_eta_monitor_core import tram_pkg::*; #(
  parameter int unsigned SESSIONS          = 4,
  parameter int unsigned HISTORY_DEPTH     = 16,
  parameter int unsigned HISTORY_WINDOW_MS = 5000
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [87:0]  s_axis_tdata,   // slot[1:0], amount[41:2], now_ms[81:42]
  input  logic [2:0]   s_axis_tuser,   // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [423:0] m_axis_tdata,   // byte_total, moved_bytes, percent_x100,
                                       // current_speed, average_speed, eta_ms,
                                       // start_time_ms, last_update_ms,
                                       // global_bytes, global_speed
  output logic         m_axis_tuser    // found
);

  tram_cmd_t    cmd;
  tram_status_t st;
  tram_result_t res;
  logic         found;
  logic         out_free;
  logic         out_load;
  logic         m_valid_q;
  logic         m_found_q;
  tram_result_t m_res_q;

  assign out_free = !m_valid_q || m_axis_tready;

  tram_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  tram_dp #(
    .SESSIONS          (SESSIONS),
    .HISTORY_DEPTH     (HISTORY_DEPTH),
    .HISTORY_WINDOW_MS (HISTORY_WINDOW_MS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (s_axis_tuser),
    .slot_i   (s_axis_tdata[1:0]),
    .amount_i (s_axis_tdata[41:2]),
    .now_i    (s_axis_tdata[81:42]),
    .cmd_i    (cmd),
    .st_o     (st),
    .found_o  (found),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_res_q   <= res;
      m_found_q <= found;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_res_q;
  assign m_axis_tuser  = m_found_q;

endmodule

FILE: bench/transfer_rate_and_eta_monitor_core_test.sv
module transfer_rate_and_eta_monitor_core_test;
  import tram_pkg::*;

  localparam int unsigned NumSlots  = 4;
  localparam int unsigned RingDepth = 16;
  localparam int unsigned WindowMs  = 5000;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned ExpDepth  = 64;
  localparam logic [39:0] Max40 = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic         found;
    tram_result_t stats;
  } slot_report_t;

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [87:0]   s_axis_tdata;
  logic [2:0]    s_axis_tuser;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [423:0]  m_axis_tdata;
  logic          m_axis_tuser;

  transfer_rate_and_eta_monitor_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // session state mirror
  logic        sess_active [NumSlots];
  logic [39:0] sess_total  [NumSlots];
  logic [47:0] sess_moved  [NumSlots];
  logic [47:0] sess_cur    [NumSlots];
  logic [47:0] sess_avg    [NumSlots];
  logic [39:0] sess_start  [NumSlots];
  logic [39:0] sess_last   [NumSlots];
  logic [39:0] ring_time   [NumSlots][RingDepth];
  logic [39:0] ring_bytes  [NumSlots][RingDepth];
  int unsigned ring_head   [NumSlots];
  int unsigned ring_fill   [NumSlots];

  slot_report_t expected_reports [ExpDepth];
  int unsigned  exp_wr = 0;
  int unsigned  exp_rd = 0;
  int unsigned  mismatches = 0;
  int unsigned  reports_seen = 0;
  int unsigned  op_count [8];
  int unsigned  idle_cycles = 0;
  int unsigned  burst_left;
  logic [39:0]  clock_ms;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic logic [39:0] rand40();
    return {8'($urandom_range(255, 0)), $urandom()};
  endfunction

  function automatic logic [63:0] clip48(input logic [63:0] v);
    return v > 64'(Max48) ? 64'(Max48) : v;
  endfunction

  function automatic void prune_ring(input int s, input logic [39:0] now);
    while (ring_fill[s] > 0 &&
           64'(ring_time[s][ring_head[s]]) + 64'(WindowMs) < 64'(now)) begin
      ring_head[s] = (ring_head[s] + 1) % RingDepth;
      ring_fill[s]--;
    end
  endfunction

  function automatic void refresh_speeds(input int s, input logic [39:0] now);
    logic [47:0] recent;
    int unsigned p;
    recent = '0;
    for (int k = 0; k < ring_fill[s]; k++) begin
      p = (ring_head[s] + k) % RingDepth;
      if (64'(ring_time[s][p]) + 64'(SpeedWindowMs) >= 64'(now))
        recent = sat_add48(recent, 48'(ring_bytes[s][p]));
    end
    sess_cur[s] = recent;
    if (now > sess_start[s])
      sess_avg[s] = 48'(clip48((64'(sess_moved[s]) * 64'd1000) / 64'(now - sess_start[s])));
    prune_ring(s, now);
  endfunction

  function automatic slot_report_t apply_request(input logic [2:0] op, input int s,
                                                 input logic [39:0] amount,
                                                 input logic [39:0] now);
    slot_report_t rep;
    logic [63:0]  pct;
    logic [47:0]  speed;
    int unsigned  p;
    rep = '0;
    if (op == OP_START) begin
      sess_active[s] = 1'b1;
      sess_total[s]  = amount;
      sess_moved[s]  = '0;
      sess_cur[s]    = '0;
      sess_avg[s]    = '0;
      sess_start[s]  = now;
      sess_last[s]   = now;
      ring_head[s]   = 0;
      ring_fill[s]   = 0;
    end else if (op == OP_END) begin
      sess_active[s] = 1'b0;
      ring_head[s]   = 0;
      ring_fill[s]   = 0;
    end else if (op == OP_BYTES && sess_active[s]) begin
      sess_moved[s] = sat_add48(sess_moved[s], 48'(amount));
      sess_last[s]  = now;
      if (ring_fill[s] >= RingDepth) begin
        ring_head[s] = (ring_head[s] + 1) % RingDepth;
        ring_fill[s]--;
      end
      p = (ring_head[s] + ring_fill[s]) % RingDepth;
      ring_time[s][p]  = now;
      ring_bytes[s][p] = amount;
      ring_fill[s]++;
      prune_ring(s, now);
    end else if (op == OP_UPDATE) begin
      for (int i = 0; i < NumSlots; i++)
        if (sess_active[i]) refresh_speeds(i, now);
    end
    for (int i = 0; i < NumSlots; i++) begin
      if (sess_active[i]) begin
        rep.stats.global_bytes = sat_add48(rep.stats.global_bytes, sess_moved[i]);
        rep.stats.global_speed = sat_add48(rep.stats.global_speed, sess_cur[i]);
      end
    end
    if (sess_active[s]) begin
      rep.found                = 1'b1;
      rep.stats.byte_total     = sess_total[s];
      rep.stats.moved_bytes    = sess_moved[s];
      rep.stats.current_speed  = sess_cur[s];
      rep.stats.average_speed  = sess_avg[s];
      rep.stats.start_time_ms  = sess_start[s];
      rep.stats.last_update_ms = sess_last[s];
      if (sess_total[s] != 0) begin
        pct = (64'(sess_moved[s]) * 64'd10000) / 64'(sess_total[s]);
        rep.stats.percent_x100 = pct > 64'(MaxPct) ? MaxPct : pct[15:0];
      end
      speed = sess_cur[s] != 0 ? sess_cur[s] : sess_avg[s];
      if (64'(sess_moved[s]) < 64'(sess_total[s]) && speed != 0)
        rep.stats.eta_ms = 48'(clip48((64'(sess_total[s]) - 64'(sess_moved[s])) * 64'd1000
                                      / 64'(speed)));
    end else begin
      rep.stats.start_time_ms  = now;
      rep.stats.last_update_ms = now;
    end
    return rep;
  endfunction

  task automatic send_request(input logic [2:0] op, input logic [1:0] s,
                              input logic [39:0] amount, input logic [39:0] now);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, now, amount, s};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_reports[exp_wr % ExpDepth] = apply_request(op, int'(s), amount, now);
    exp_wr++;
    op_count[op]++;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
      burst_left = $urandom_range(3) == 0 ? 40 : $urandom_range(8, 1);
    end else begin
      burst_left--;
    end
  endtask

  // receiver: stall pattern switches between random styles, set by a phase counter
  int unsigned stall_style;
  int unsigned stall_phase;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_style   <= 0;
      stall_phase   <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 63) stall_style <= $urandom_range(3);
      case (stall_style)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(1));
        2: m_axis_tready <= $urandom_range(5) == 0;
        default: m_axis_tready <= stall_phase[2];
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      slot_report_t got;
      slot_report_t want;
      got.found = m_axis_tuser;
      got.stats = tram_result_t'(m_axis_tdata);
      reports_seen++;
      if (exp_rd == exp_wr) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %h", m_axis_tdata);
      end else begin
        want = expected_reports[exp_rd % ExpDepth];
        exp_rd++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d mismatch", reports_seen);
            $display("  found  exp %0d got %0d", want.found, got.found);
            $display("  total  exp %0d got %0d", want.stats.byte_total,
                     got.stats.byte_total);
            $display("  moved  exp %0d got %0d", want.stats.moved_bytes,
                     got.stats.moved_bytes);
            $display("  pct    exp %0d got %0d", want.stats.percent_x100,
                     got.stats.percent_x100);
            $display("  cur    exp %0d got %0d", want.stats.current_speed,
                     got.stats.current_speed);
            $display("  avg    exp %0d got %0d", want.stats.average_speed,
                     got.stats.average_speed);
            $display("  eta    exp %0d got %0d", want.stats.eta_ms, got.stats.eta_ms);
            $display("  start  exp %0d got %0d", want.stats.start_time_ms,
                     got.stats.start_time_ms);
            $display("  last   exp %0d got %0d", want.stats.last_update_ms,
                     got.stats.last_update_ms);
            $display("  gbytes exp %0d got %0d", want.stats.global_bytes,
                     got.stats.global_bytes);
            $display("  gspeed exp %0d got %0d", want.stats.global_speed,
                     got.stats.global_speed);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic advance_clock(input int unsigned step);
    clock_ms = clock_ms + 40'(step);
  endtask

  task automatic test_session_lifecycle();
    clock_ms = 40'd1000;
    send_request(OP_QUERY, 2'd0, 40'd0, clock_ms);
    send_request(OP_END, 2'd1, 40'd0, clock_ms);
    send_request(OP_BYTES, 2'd2, 40'd55, clock_ms);
    send_request(OP_START, 2'd0, 40'd0, clock_ms);
    send_request(OP_BYTES, 2'd0, 40'd10, clock_ms);
    send_request(OP_UPDATE, 2'd3, 40'd0, clock_ms);
    send_request(OP_START, 2'd1, 40'd100000, clock_ms);
    advance_clock(250);
    send_request(OP_BYTES, 2'd1, 40'd30000, clock_ms);
    advance_clock(500);
    send_request(OP_BYTES, 2'd1, 40'd20000, clock_ms);
    advance_clock(700);
    send_request(OP_UPDATE, 2'd1, 40'd0, clock_ms);
    advance_clock(3000);
    send_request(OP_UPDATE, 2'd1, 40'd0, clock_ms);
    send_request(OP_BYTES, 2'd1, 40'd60000, clock_ms);
    send_request(OP_END, 2'd1, 40'd0, clock_ms);
    send_request(OP_QUERY, 2'd1, 40'd0, clock_ms);
  endtask

  task automatic test_field_extremes();
    send_request(OP_START, 2'd3, Max40, Max40 - 40'd6000);
    send_request(OP_BYTES, 2'd3, Max40, Max40 - 40'd5999);
    send_request(OP_UPDATE, 2'd3, 40'd0, Max40);
    send_request(3'd5, 2'd3, Max40, Max40);
    send_request(3'd6, 2'd2, 40'd0, Max40);
    send_request(3'd7, 2'd3, 40'h55_5555_5555, Max40);
    // time goes backwards: no wrap in the window or elapsed logic
    send_request(OP_UPDATE, 2'd3, 40'd0, 40'd3);
    send_request(OP_BYTES, 2'd3, 40'd1, 40'd2);
    send_request(OP_END, 2'd3, 40'd0, 40'd2);
  endtask

  task automatic test_random_transfers(input int unsigned items);
    logic [2:0]  op;
    logic [1:0]  s;
    logic [39:0] amount;
    clock_ms = rand40() >> $urandom_range(39, 1);
    for (int n = 0; n < items; n++) begin
      s = 2'($urandom_range(3));
      amount = 40'($urandom_range(50000));
      if ($urandom_range(9) == 0) amount = rand40() >> $urandom_range(39);
      case ($urandom_range(19))
        0, 1:    op = OP_START;
        2:       op = OP_END;
        3, 4, 5: op = OP_UPDATE;
        6:       op = OP_QUERY;
        7:       op = 3'($urandom_range(7));
        default: op = sess_active[s] ? OP_BYTES : OP_START;
      endcase
      if (op == OP_START) amount = $urandom_range(3) == 0 ? rand40() : amount * 40'd40;
      case ($urandom_range(9))
        0:       advance_clock($urandom_range(7000, 1000));
        1, 2:    advance_clock(0);
        default: advance_clock($urandom_range(600));
      endcase
      if ($urandom_range(199) == 0) clock_ms = rand40() >> 1;
      send_request(op, s, amount, clock_ms);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_QUERY;
    burst_left    = 4;
    for (int i = 0; i < 8; i++) op_count[i] = 0;
    for (int i = 0; i < NumSlots; i++) begin
      sess_active[i] = 1'b0;
      sess_total[i]  = '0;
      sess_moved[i]  = '0;
      sess_cur[i]    = '0;
      sess_avg[i]    = '0;
      sess_start[i]  = '0;
      sess_last[i]   = '0;
      ring_head[i]   = 0;
      ring_fill[i]   = 0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_session_lifecycle();
    test_field_extremes();
    test_random_transfers(1050);

    s_axis_tvalid <= 1'b0;
    while (exp_rd != exp_wr) @(posedge clk_i);
    repeat (600) @(posedge clk_i);

    $display("requests: start %0d, end %0d, bytes %0d, update %0d, query %0d, other %0d",
             op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
             op_count[5] + op_count[6] + op_count[7]);
    $display("results checked: %0d, mismatches: %0d", reports_seen, mismatches);
    if (mismatches == 0 && exp_rd == exp_wr) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
